FILE: hw/rtl/dda_pkg.sv
// Shared constants for the DDA line rasteriser.
package dda_pkg;

  // Controller state codes.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

endpackage

FILE: hw/rtl/dda_if.sv
// Valid/ready channel interfaces for lines in and points out.
interface dda_in_if #(
  parameter int COORD_BITS = 6
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;

  modport source (output valid, output x_start, output y_start, output x_end, output y_end,
                  input ready);
  modport sink   (input valid, input x_start, input y_start, input x_end, input y_end,
                  output ready);
endinterface

interface dda_out_if #(
  parameter int COORD_BITS = 6
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input last_point,
                  output ready);
endinterface

FILE: hw/rtl/dda_line_rasterizer_core.sv
// DDA line rasteriser: accepts one line and streams out its points.
//
// A line transaction on line_i carries two signed endpoints. The core takes
// the larger absolute span as the step count and forms one fixed-point
// increment per axis by a bit-serial restoring divider, one quotient bit per
// cycle for each axis. It then streams steps+1 points on point_o, one per
// cycle while the sink is ready, and flags the final point with last_point.
// A zero-length line gives the start point alone, flagged as last.
// line_i.ready is high only while the core holds no line, so the next line
// can be taken only once the last point transaction has returned the
// controller to idle.
// A stalled sink holds the current point steady on point_o; the accumulators
// advance only when a point transaction completes.
// Reset returns the controller to idle: point_o.valid is low and line_i.ready
// is high.
module dda_line_rasterizer_core #(
  parameter int COORD_BITS = 6,
  parameter int FRAC_BITS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dda_in_if.sink    line_i,
  dda_out_if.source point_o
);
  import dda_pkg::*;

  localparam int DVD_W  = COORD_BITS + FRAC_BITS;
  localparam int ACC_W  = COORD_BITS + FRAC_BITS;
  localparam int INC_W  = FRAC_BITS + 2;
  localparam int DCNT_W = $clog2(DVD_W + 1);

  logic [1:0]            state_q, state_d;
  logic [DCNT_W-1:0]     dcnt_q, dcnt_d;
  logic [COORD_BITS-1:0] k_q, k_d;
  logic [COORD_BITS-1:0] steps_q, steps_d;
  logic [COORD_BITS-1:0] rem_x_q, rem_x_d, rem_y_q, rem_y_d;
  logic [DVD_W-1:0]      dvx_q, dvx_d, dvy_q, dvy_d;
  logic                  neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic [ACC_W-1:0]      acc_x_q, acc_x_d, acc_y_q, acc_y_d;

  logic [COORD_BITS:0]   dx, dy, adx_w, ady_w;
  logic [COORD_BITS-1:0] adx, ady;
  logic [COORD_BITS:0]   rx_sh, ry_sh, rx_sub, ry_sub;
  logic                  rx_ge, ry_ge;
  logic [INC_W-1:0]      inc_x, inc_y;
  logic                  last;

  // Span of each axis, one bit wider than the coordinates.
  assign dx    = {line_i.x_end[COORD_BITS-1], line_i.x_end}
               - {line_i.x_start[COORD_BITS-1], line_i.x_start};
  assign dy    = {line_i.y_end[COORD_BITS-1], line_i.y_end}
               - {line_i.y_start[COORD_BITS-1], line_i.y_start};
  assign adx_w = dx[COORD_BITS] ? -dx : dx;
  assign ady_w = dy[COORD_BITS] ? -dy : dy;
  assign adx   = adx_w[COORD_BITS-1:0];
  assign ady   = ady_w[COORD_BITS-1:0];

  // One restoring division step per axis.
  assign rx_sh  = {rem_x_q, dvx_q[DVD_W-1]};
  assign ry_sh  = {rem_y_q, dvy_q[DVD_W-1]};
  assign rx_ge  = rx_sh >= {1'b0, steps_q};
  assign ry_ge  = ry_sh >= {1'b0, steps_q};
  assign rx_sub = rx_sh - {1'b0, steps_q};
  assign ry_sub = ry_sh - {1'b0, steps_q};

  // The quotient never exceeds 2^FRAC_BITS, so its low FRAC_BITS+1 bits suffice.
  assign inc_x = neg_x_q ? -{1'b0, dvx_q[FRAC_BITS:0]} : {1'b0, dvx_q[FRAC_BITS:0]};
  assign inc_y = neg_y_q ? -{1'b0, dvy_q[FRAC_BITS:0]} : {1'b0, dvy_q[FRAC_BITS:0]};

  assign last = (k_q == steps_q);

  always_comb begin
    state_d = state_q;
    dcnt_d  = dcnt_q;
    k_d     = k_q;
    steps_d = steps_q;
    rem_x_d = rem_x_q;
    rem_y_d = rem_y_q;
    dvx_d   = dvx_q;
    dvy_d   = dvy_q;
    neg_x_d = neg_x_q;
    neg_y_d = neg_y_q;
    acc_x_d = acc_x_q;
    acc_y_d = acc_y_q;
    unique case (state_q)
      ST_IDLE: begin
        if (line_i.valid) begin
          steps_d = (adx > ady) ? adx : ady;
          rem_x_d = '0;
          rem_y_d = '0;
          dvx_d   = {adx, {FRAC_BITS{1'b0}}};
          dvy_d   = {ady, {FRAC_BITS{1'b0}}};
          neg_x_d = dx[COORD_BITS];
          neg_y_d = dy[COORD_BITS];
          acc_x_d = {line_i.x_start, {FRAC_BITS{1'b0}}};
          acc_y_d = {line_i.y_start, {FRAC_BITS{1'b0}}};
          k_d     = '0;
          dcnt_d  = DCNT_W'(DVD_W);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_x_d = rx_ge ? rx_sub[COORD_BITS-1:0] : rx_sh[COORD_BITS-1:0];
        rem_y_d = ry_ge ? ry_sub[COORD_BITS-1:0] : ry_sh[COORD_BITS-1:0];
        dvx_d   = {dvx_q[DVD_W-2:0], rx_ge};
        dvy_d   = {dvy_q[DVD_W-2:0], ry_ge};
        dcnt_d  = dcnt_q - 1'b1;
        if (dcnt_q == DCNT_W'(1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (point_o.ready) begin
          if (last) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            acc_x_d = acc_x_q + {{(ACC_W-INC_W){inc_x[INC_W-1]}}, inc_x};
            acc_y_d = acc_y_q + {{(ACC_W-INC_W){inc_y[INC_W-1]}}, inc_y};
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dcnt_q  <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      dcnt_q  <= dcnt_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    steps_q <= steps_d;
    rem_x_q <= rem_x_d;
    rem_y_q <= rem_y_d;
    dvx_q   <= dvx_d;
    dvy_q   <= dvy_d;
    neg_x_q <= neg_x_d;
    neg_y_q <= neg_y_d;
    acc_x_q <= acc_x_d;
    acc_y_q <= acc_y_d;
  end

  assign line_i.ready = (state_q == ST_IDLE);

  // Arithmetic shift floors; a negative value with a fraction is bumped up to
  // truncate toward zero.
  assign point_o.valid      = (state_q == ST_EMIT);
  assign point_o.point_x    = acc_x_q[ACC_W-1:FRAC_BITS]
                            + {{(COORD_BITS-1){1'b0}},
                               acc_x_q[ACC_W-1] & (|acc_x_q[FRAC_BITS-1:0])};
  assign point_o.point_y    = acc_y_q[ACC_W-1:FRAC_BITS]
                            + {{(COORD_BITS-1){1'b0}},
                               acc_y_q[ACC_W-1] & (|acc_y_q[FRAC_BITS-1:0])};
  assign point_o.last_point = last;

endmodule

FILE: tb/dda_point_checker.sv
// Point checker for the DDA line rasteriser: predicts each line's points and compares them.
module dda_point_checker #(
  parameter int COORD_BITS = 6,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  dda_in_if    line_mon,
  dda_out_if   point_mon,
  output int   fail_count_o,
  output int   expected_left_o,
  output int   points_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         last;
  } point_t;

  point_t expected_points[$];
  int     mismatches;
  int     checked;

  // Span scaled by 2^FRAC_BITS over the step count, rounded toward zero.
  function automatic longint fixed_step(input longint span, input longint steps);
    longint q;
    q = ((span < 0) ? -span : span) <<< FRAC_BITS;
    q = q / steps;
    return (span < 0) ? -q : q;
  endfunction

  // Accumulator truncated toward zero and wrapped to the coordinate width.
  function automatic logic signed [COORD_BITS-1:0] to_coord(input longint acc);
    longint m;
    m = ((acc < 0) ? -acc : acc) >>> FRAC_BITS;
    if (acc < 0) begin
      m = -m;
    end
    return m[COORD_BITS-1:0];
  endfunction

  function automatic void plot_dda_line(input logic signed [COORD_BITS-1:0] xs_i,
                                        input logic signed [COORD_BITS-1:0] ys_i,
                                        input logic signed [COORD_BITS-1:0] xe_i,
                                        input logic signed [COORD_BITS-1:0] ye_i);
    longint xs, ys, dx, dy, adx, ady, steps, xinc, yinc, xacc, yacc, k;
    point_t pt;
    xs    = xs_i;
    ys    = ys_i;
    dx    = longint'(xe_i) - xs;
    dy    = longint'(ye_i) - ys;
    adx   = (dx < 0) ? -dx : dx;
    ady   = (dy < 0) ? -dy : dy;
    steps = (adx > ady) ? adx : ady;
    xinc  = 0;
    yinc  = 0;
    // A zero-length line skips the division and yields the start point alone.
    if (steps != 0) begin
      xinc = fixed_step(dx, steps);
      yinc = fixed_step(dy, steps);
    end
    xacc = xs * (longint'(1) <<< FRAC_BITS);
    yacc = ys * (longint'(1) <<< FRAC_BITS);
    for (k = 0; k <= steps; k++) begin
      if (k != 0) begin
        xacc += xinc;
        yacc += yinc;
      end
      pt.x    = to_coord(xacc);
      pt.y    = to_coord(yacc);
      pt.last = (k == steps);
      expected_points.push_back(pt);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    point_t want;
    logic   bad;
    if (!rst_ni) begin
      mismatches      <= 0;
      checked         <= 0;
      expected_left_o <= 0;
    end else begin
      if (line_mon.valid && line_mon.ready) begin
        plot_dda_line(line_mon.x_start, line_mon.y_start, line_mon.x_end, line_mon.y_end);
      end
      if (point_mon.valid && point_mon.ready) begin
        if (expected_points.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected point x=%0d y=%0d last=%0b", $realtime,
                     point_mon.point_x, point_mon.point_y, point_mon.last_point);
          end
          mismatches <= mismatches + 1;
        end else begin
          want = expected_points.pop_front();
          bad  = 1'b0;
          if (point_mon.point_x !== want.x) bad = 1'b1;
          if (point_mon.point_y !== want.y) bad = 1'b1;
          if (point_mon.last_point !== want.last) bad = 1'b1;
          if (bad) begin
            if (mismatches < 10) begin
              $display({"%0t: point mismatch, expected x=%0d y=%0d last=%0b, ",
                        "got x=%0d y=%0d last=%0b"},
                       $realtime, want.x, want.y, want.last,
                       point_mon.point_x, point_mon.point_y, point_mon.last_point);
            end
            mismatches <= mismatches + 1;
          end
          checked <= checked + 1;
        end
      end
      expected_left_o <= expected_points.size();
    end
  end

  assign fail_count_o     = mismatches;
  assign points_checked_o = checked;

endmodule

FILE: tb/testbench.sv
// Top of the DDA line rasteriser testbench: clock, reset, line and sink stimulus, verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB          = 6;
  localparam int FB          = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int LO          = -(1 << (CB - 1));
  localparam int HI          = (1 << (CB - 1)) - 1;

  logic clk_i;
  logic rst_ni;

  dda_in_if  #(.COORD_BITS(CB)) line_if ();
  dda_out_if #(.COORD_BITS(CB)) point_if ();

  int fail_count;
  int expected_left;
  int points_checked;
  int cycles;
  int lines_sent;
  int hold_requests;
  int holds_done;
  bit no_gaps;

  dda_line_rasterizer_core #(
    .COORD_BITS(CB),
    .FRAC_BITS (FB)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .line_i (line_if),
    .point_o(point_if)
  );

  dda_point_checker #(
    .COORD_BITS(CB),
    .FRAC_BITS (FB)
  ) chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .line_mon        (line_if),
    .point_mon       (point_if),
    .fail_count_o    (fail_count),
    .expected_left_o (expected_left),
    .points_checked_o(points_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d points outstanding", cycles, expected_left);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int clamp_coord(input int v);
    if (v < LO) return LO;
    if (v > HI) return HI;
    return v;
  endfunction

  // Offers one line, with random idle cycles first unless no_gaps is set, and returns at the
  // falling edge after the transaction.
  task automatic send_line(input int xs, input int ys, input int xe, input int ye);
    while (!no_gaps && $urandom_range(99) < 22) begin
      line_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    line_if.valid   <= 1'b1;
    line_if.x_start <= xs[CB-1:0];
    line_if.y_start <= ys[CB-1:0];
    line_if.x_end   <= xe[CB-1:0];
    line_if.y_end   <= ye[CB-1:0];
    do @(posedge clk_i); while (!(line_if.valid && line_if.ready));
    @(negedge clk_i);
    lines_sent++;
  endtask

  task automatic send_random_line();
    int kind, xs, ys, xe, ye, len, dir;
    kind = $urandom_range(99);
    xs   = $urandom_range(HI - LO) + LO;
    ys   = $urandom_range(HI - LO) + LO;
    xe   = $urandom_range(HI - LO) + LO;
    ye   = $urandom_range(HI - LO) + LO;
    if (kind < 40) begin
      // Endpoints anywhere in the coordinate range.
    end else if (kind < 75) begin
      xe = clamp_coord(xs + int'($urandom_range(8)) - 4);
      ye = clamp_coord(ys + int'($urandom_range(8)) - 4);
    end else if (kind < 85) begin
      xe = xs;
      ye = ys;
    end else if (kind < 95) begin
      // Horizontal, vertical or diagonal runs.
      len = $urandom_range(HI - LO);
      dir = $urandom_range(7);
      xe  = clamp_coord(xs + ((dir == 0 || dir == 4 || dir == 5) ? len :
                              (dir == 1 || dir == 6 || dir == 7) ? -len : 0));
      ye  = clamp_coord(ys + ((dir == 2 || dir == 4 || dir == 6) ? len :
                              (dir == 3 || dir == 5 || dir == 7) ? -len : 0));
    end else begin
      xs = $urandom_range(1) ? HI : LO;
      ys = $urandom_range(1) ? HI : LO;
      xe = $urandom_range(1) ? HI : LO;
      ye = $urandom_range(1) ? HI : LO;
    end
    send_line(xs, ys, xe, ye);
  endtask

  // Point sink: random back-pressure, a steady stretch, and one long hold-off on request.
  initial begin
    point_if.ready = 1'b0;
    holds_done     = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_done) begin
        point_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        holds_done++;
      end else begin
        point_if.ready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 22);
      end
    end
  end

  initial begin
    lines_sent      = 0;
    hold_requests   = 0;
    no_gaps         = 1'b0;
    rst_ni          = 1'b0;
    line_if.valid   = 1'b0;
    line_if.x_start = '0;
    line_if.y_start = '0;
    line_if.x_end   = '0;
    line_if.y_end   = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Zero-length lines, full spans, axis-aligned lines and short lines whose truncated
    // increments leave the final point short of the end point.
    send_line(LO, LO, LO, LO);
    send_line(HI, HI, HI, HI);
    send_line(0, 0, 0, 0);
    send_line(LO, LO, HI, HI);
    send_line(HI, HI, LO, LO);
    send_line(LO, HI, HI, LO);
    send_line(HI, LO, LO, HI);
    send_line(LO, 5, HI, 5);
    send_line(HI, -7, LO, -7);
    send_line(3, LO, 3, HI);
    send_line(-4, HI, -4, LO);
    send_line(0, 0, 3, 1);
    send_line(0, 0, -3, -1);
    send_line(0, 0, 7, 3);
    send_line(-1, -1, -6, 2);
    send_line(0, 0, -31, -30);
    send_line(5, -5, -5, 5);
    send_line(0, 0, 1, 0);
    send_line(0, 0, 0, -1);
    send_line(LO, 0, HI, 1);

    for (int i = 0; i < 380; i++) begin
      if (i == 60) begin
        // The sink stalls for a long stretch while lines keep being offered.
        hold_requests++;
      end
      no_gaps = (i >= 150 && i < 210);
      if (i == 250) begin
        line_if.valid <= 1'b0;
        do @(negedge clk_i); while (expected_left != 0);
      end
      send_random_line();
    end
    line_if.valid <= 1'b0;

    while (expected_left != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Sent %0d lines and checked %0d points, covering zero-length, full-span,",
             lines_sent, points_checked);
    $display("axis-aligned and short lines under random and long sink stalls.");
    if (fail_count == 0 && expected_left == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
